### rtl/pcmfc_pkg.sv
// Shared types and constants for the PCM sample format converter.
// Holds the configuration register indexes and the encoded-sample job record.
// No dependencies.
package pcmfc_pkg;

  // Configuration register indexes on the configuration port.
  typedef enum logic [3:0] {
    REG_IN_WIDE           = 4'd0,
    REG_IN_SIGNED         = 4'd1,
    REG_IN_BIG_ENDIAN     = 4'd2,
    REG_IN_CHANNEL_COUNT  = 4'd3,
    REG_OUT_WIDE          = 4'd4,
    REG_OUT_SIGNED        = 4'd5,
    REG_OUT_BIG_ENDIAN    = 4'd6,
    REG_OUT_CHANNEL_COUNT = 4'd7
  } cfg_reg_t;

  localparam logic [15:0] SIGN_FLIP16 = 16'h8000;
  localparam logic [7:0]  SIGN_FLIP8  = 8'h80;

  // One encoded output sample: the bytes in stream order and its width.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       wide;
  } job_t;

endpackage

### rtl/pcmfc_emitter.sv
// Output emitter of the PCM sample format converter: repeats one encoded
// sample a given number of times, one byte per beat, from its own registers.
// Depends on pcmfc_pkg.
module pcmfc_emitter
  import pcmfc_pkg::*;
#(
  parameter int CNT_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_ready,
  input  job_t             job,
  input  logic [CNT_W-1:0] job_count,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             run_end
);

  logic             busy;
  logic             phase;
  logic [CNT_W-1:0] rem;
  job_t             cur;

  assign job_ready = !busy;
  assign out_valid = busy;
  assign out_byte  = phase ? cur.byte1 : cur.byte0;
  assign run_end   = (rem == CNT_W'(1)) && (phase || !cur.wide);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (!busy) begin
      if (job_valid) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        rem   <= job_count;
        cur   <= job;
      end
    end else if (out_ready) begin
      if (run_end) begin
        busy  <= 1'b0;
        phase <= 1'b0;
      end else if (cur.wide && !phase) begin
        phase <= 1'b1;
      end else begin
        phase <= 1'b0;
        rem   <= rem - CNT_W'(1);
      end
    end
  end

  a_busy_has_bytes : assert property (@(posedge clk) disable iff (rst)
    busy |-> rem != '0)
    else $error("emitter busy with no samples left");

  a_phase_only_wide : assert property (@(posedge clk) disable iff (rst)
    (busy && phase) |-> cur.wide)
    else $error("second byte phase on a narrow sample");

  a_last_frees : assert property (@(posedge clk) disable iff (rst)
    (busy && out_ready && run_end) |=> !busy)
    else $error("emitter still busy after its last byte");

endmodule

### rtl/pcm_sample_format_converter.sv
// Top level of the PCM sample format converter.
// Holds configuration registers, input sample assembly and decode, and a job
// register that feeds pcmfc_emitter. Depends on pcmfc_pkg and pcmfc_emitter.
//
// Usage: raw input bytes arrive on in_byte with in_valid/in_ready; output
// bytes leave on out_byte with out_valid/out_ready, and run_end marks the last
// byte produced by one input byte. The user must write configuration through
// cfg_valid/cfg_index/cfg_data (always ready) only while the block is idle;
// the block itself does not enforce this. A byte that completes a sample is
// decoded in the accepting cycle into an encoded sample and a repeat count
// held in the job register, then loaded into the emitter's registers. The
// emitter gives one byte per cycle while out_ready is high, and goes idle
// after its last byte before it takes its next job. An input byte causes 1
// to 2 * MAX_CHANNELS output bytes; bytes that complete no sample, or whose
// channel is dropped, make none. One further input byte is held in the job
// register while the emitter works. When the receiver stalls, the current
// byte holds, the job register fills and in_ready falls. Reset restores the
// default format (16-bit signed little-endian stereo on both sides) and
// clears the held byte, byte phase and channel position.
module pcm_sample_format_converter
  import pcmfc_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_end,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

  // Configuration registers.
  logic       in_wide, in_signed, in_big_endian;
  logic [3:0] in_channel_count;
  logic       out_wide, out_signed, out_big_endian;
  logic [3:0] out_channel_count;

  // Stream state.
  logic [7:0]      held_byte;
  logic            byte_phase;
  logic [CH_W-1:0] channel_index;

  // Job register between decode and emitter.
  logic             pend_valid;
  job_t             pend_job;
  logic [CNT_W-1:0] pend_count;
  logic             emit_ready;

  logic             in_fire;
  logic             sample_done;
  logic [15:0]      sample;
  logic [15:0]      out_word;
  logic [7:0]       narrow_byte;
  logic [4:0]       in_n5, out_n5;
  logic [CNT_W-1:0] in_n, out_n, chan;
  logic [CNT_W:0]   chan_inc;
  logic             frame_end;
  logic [CNT_W-1:0] count_next;
  job_t             job_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = !pend_valid || emit_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_wide           <= 1'b1;
      in_signed         <= 1'b1;
      in_big_endian     <= 1'b0;
      in_channel_count  <= 4'd2;
      out_wide          <= 1'b1;
      out_signed        <= 1'b1;
      out_big_endian    <= 1'b0;
      out_channel_count <= 4'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IN_WIDE:           in_wide           <= cfg_data[0];
        REG_IN_SIGNED:         in_signed         <= cfg_data[0];
        REG_IN_BIG_ENDIAN:     in_big_endian     <= cfg_data[0];
        REG_IN_CHANNEL_COUNT:  in_channel_count  <= cfg_data;
        REG_OUT_WIDE:          out_wide          <= cfg_data[0];
        REG_OUT_SIGNED:        out_signed        <= cfg_data[0];
        REG_OUT_BIG_ENDIAN:    out_big_endian    <= cfg_data[0];
        REG_OUT_CHANNEL_COUNT: out_channel_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Channel counts: zero means one, and anything above the limit is clamped.
  always_comb begin
    in_n5 = (in_channel_count == 4'd0) ? 5'd1 :
            ({1'b0, in_channel_count} > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) :
            {1'b0, in_channel_count};
    out_n5 = (out_channel_count == 4'd0) ? 5'd1 :
             ({1'b0, out_channel_count} > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) :
             {1'b0, out_channel_count};
    in_n  = in_n5[CNT_W-1:0];
    out_n = out_n5[CNT_W-1:0];
  end

  // Sample assembly and widening to a 16-bit two's complement pattern.
  always_comb begin
    sample_done = !in_wide || byte_phase;
    if (in_wide) begin
      sample = in_big_endian ? {held_byte, in_byte} : {in_byte, held_byte};
      if (!in_signed) begin
        sample = sample ^ SIGN_FLIP16;
      end
    end else begin
      sample = {(in_signed ? in_byte : (in_byte ^ SIGN_FLIP8)), 8'h00};
    end
  end

  // Re-encoding. Narrow signed output rounds toward zero, so a negative
  // sample with a non-zero low byte moves its top byte up by one.
  always_comb begin
    out_word = out_signed ? sample : (sample ^ SIGN_FLIP16);
    if (out_signed) begin
      narrow_byte = sample[15:8] + 8'((sample[15] && (sample[7:0] != 8'h00)) ? 1 : 0);
    end else begin
      narrow_byte = sample[15:8] ^ SIGN_FLIP8;
    end
    job_next.wide = out_wide;
    if (out_wide) begin
      job_next.byte0 = out_big_endian ? out_word[15:8] : out_word[7:0];
      job_next.byte1 = out_big_endian ? out_word[7:0] : out_word[15:8];
    end else begin
      job_next.byte0 = narrow_byte;
      job_next.byte1 = narrow_byte;
    end
  end

  // How many copies of the sample go out: the channel's own, plus the
  // remaining output channels when it closes the input frame; none past out_n.
  always_comb begin
    chan      = CNT_W'(channel_index);
    chan_inc  = {1'b0, chan} + (CNT_W+1)'(1);
    frame_end = chan_inc >= {1'b0, in_n};
    if (chan < out_n) begin
      count_next = frame_end ? (out_n - chan) : CNT_W'(1);
    end else begin
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte     <= 8'h00;
      byte_phase    <= 1'b0;
      channel_index <= '0;
      pend_valid    <= 1'b0;
    end else begin
      // A new job may land in the same cycle as the emitter takes the old one.
      if (in_fire && sample_done && (count_next != '0)) begin
        pend_valid <= 1'b1;
        pend_job   <= job_next;
        pend_count <= count_next;
      end else if (emit_ready) begin
        pend_valid <= 1'b0;
      end
      if (in_fire) begin
        if (in_wide && !byte_phase) begin
          held_byte  <= in_byte;
          byte_phase <= 1'b1;
        end else begin
          byte_phase    <= 1'b0;
          channel_index <= frame_end ? '0 : chan_inc[CH_W-1:0];
        end
      end
    end
  end

  pcmfc_emitter #(
    .CNT_W (CNT_W)
  ) u_emitter (
    .clk       (clk),
    .rst       (rst),
    .job_valid (pend_valid),
    .job_ready (emit_ready),
    .job       (pend_job),
    .job_count (pend_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_end   (run_end)
  );

  a_job_nonempty : assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> pend_count != '0)
    else $error("job register holds a job with no samples");

  a_narrow_clears_phase : assert property (@(posedge clk) disable iff (rst)
    (in_fire && sample_done) |=> !byte_phase)
    else $error("byte phase left set after a completed sample");

  a_first_byte_no_job : assert property (@(posedge clk) disable iff (rst)
    (in_fire && !sample_done && !pend_valid) |=> !pend_valid)
    else $error("job raised by the first byte of a wide sample");

endmodule

### dv/pcm_sample_format_converter_checker.sv
// Checker for the PCM sample format converter: mirrors the format registers,
// predicts every output byte of each accepted input byte and compares them.
// Depends on pcmfc_pkg for the register indexes and sign-flip constants.
module pcm_reformat_checker
  import pcmfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       run_end,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [3:0] cfg_index,
  input  logic [3:0] cfg_data,
  output int         errors,
  output int         pending,
  output int         out_beats
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNEL_LIMIT = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  // Mirrored format registers.
  logic       src_wide, src_signed, src_big;
  logic [3:0] src_chans;
  logic       dst_wide, dst_signed, dst_big;
  logic [3:0] dst_chans;

  // Mirrored stream position.
  logic [7:0] held;
  logic       phase;
  int         chan_pos;

  logic [7:0] burst[$];
  out_beat_t  due_bytes[$];
  out_beat_t  want;

  function automatic int active_chans(logic [3:0] count);
    if (count == 4'd0) return 1;
    if (count > CHANNEL_LIMIT) return CHANNEL_LIMIT;
    return int'(count);
  endfunction

  function void apply_register(logic [3:0] idx, logic [3:0] val);
    case (idx)
      REG_IN_WIDE:           src_wide   = val[0];
      REG_IN_SIGNED:         src_signed = val[0];
      REG_IN_BIG_ENDIAN:     src_big    = val[0];
      REG_IN_CHANNEL_COUNT:  src_chans  = val;
      REG_OUT_WIDE:          dst_wide   = val[0];
      REG_OUT_SIGNED:        dst_signed = val[0];
      REG_OUT_BIG_ENDIAN:    dst_big    = val[0];
      REG_OUT_CHANNEL_COUNT: dst_chans  = val;
      default: ;
    endcase
  endfunction

  // Re-encodes one signed 16-bit sample in the output format.
  function void encode_sample(logic [15:0] s);
    logic [15:0] v;
    logic [7:0]  hi;
    if (dst_wide) begin
      v = dst_signed ? s : s ^ SIGN_FLIP16;
      if (dst_big) begin
        burst.push_back(v[15:8]);
        burst.push_back(v[7:0]);
      end else begin
        burst.push_back(v[7:0]);
        burst.push_back(v[15:8]);
      end
    end else if (dst_signed) begin
      // Division by 256 rounds negative values toward zero.
      hi = s[15:8];
      if (s[15] && s[7:0] != 8'h00) hi = hi + 8'd1;
      burst.push_back(hi);
    end else begin
      burst.push_back(s[15:8] ^ SIGN_FLIP8);
    end
  endfunction

  function void convert_byte(logic [7:0] b);
    logic [15:0] s;
    int          n_in, n_out, ch;
    n_in  = active_chans(src_chans);
    n_out = active_chans(dst_chans);
    ch    = chan_pos;
    if (src_wide) begin
      if (!phase) begin
        held  = b;
        phase = 1'b1;
        return;
      end
      phase = 1'b0;
      s = src_big ? {held, b} : {b, held};
      if (!src_signed) s = s ^ SIGN_FLIP16;
    end else begin
      phase = 1'b0;
      s = {(src_signed ? b : b ^ SIGN_FLIP8), 8'h00};
    end
    burst.delete();
    if (ch < n_out) begin
      encode_sample(s);
      // The last input channel of a frame fills the remaining output channels.
      if (ch + 1 >= n_in) begin
        for (int d = ch + 1; d < n_out; d++) encode_sample(s);
      end
    end
    chan_pos = (ch + 1 >= n_in) ? 0 : ch + 1;
    foreach (burst[k]) due_bytes.push_back('{burst[k], k == burst.size() - 1});
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      src_wide   = 1'b1;
      src_signed = 1'b1;
      src_big    = 1'b0;
      src_chans  = 4'd2;
      dst_wide   = 1'b1;
      dst_signed = 1'b1;
      dst_big    = 1'b0;
      dst_chans  = 4'd2;
      held       = 8'h00;
      phase      = 1'b0;
      chan_pos   = 0;
      due_bytes.delete();
      errors     = 0;
      out_beats  = 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (in_valid && in_ready) convert_byte(in_byte);
      if (out_valid && out_ready) begin
        out_beats++;
        if (due_bytes.size() == 0) begin
          errors++;
          $display("%0t: output beat with nothing expected: out_byte %h run_end %b",
                   $time, out_byte, run_end);
        end else begin
          want = due_bytes.pop_front();
          if (out_byte !== want.data) begin
            errors++;
            $display("%0t: out_byte expected %h, got %h", $time, want.data, out_byte);
          end
          if (run_end !== want.last) begin
            errors++;
            $display("%0t: run_end expected %b, got %b", $time, want.last, run_end);
          end
        end
      end
    end
    pending = due_bytes.size();
  end

endmodule

### dv/pcm_sample_format_converter_test.sv
// Testbench top for the PCM sample format converter: drives bytes and
// register writes under varied flow control and gives the verdict.
// Depends on pcmfc_pkg, the converter RTL and pcm_reformat_checker.
module pcm_sample_format_converter_test;
  import pcmfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] UNUSED_REG_LO = 4'd9;
  localparam logic [3:0] UNUSED_REG_HI = 4'd15;
  localparam int         DRAIN_CYCLES  = 8;
  localparam int         RANDOM_PHASES = 8;
  localparam int         PHASE_BYTES   = 40;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid, in_ready;
  logic [7:0] in_byte;
  logic       out_valid, out_ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       cfg_valid, cfg_ready;
  logic [3:0] cfg_index, cfg_data;

  int errors, pending, out_beats;
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int bytes_sent    = 0;
  int reg_writes    = 0;

  pcm_sample_format_converter DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_end   (run_end),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pcm_reformat_checker conv_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_end   (run_end),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .out_beats (out_beats)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= sink_stall_pct);
  end

  // Called and returning at a falling edge; the beat is held until accepted.
  task automatic push_byte(input logic [7:0] b);
    cfg_valid = 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic cfg_write(input logic [3:0] idx, input logic [3:0] val);
    in_valid  = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    reg_writes++;
  endtask

  // Lets every expected byte drain, then allows for bytes still in flight
  // that produce no output.
  task automatic settle();
    in_valid  = 1'b0;
    cfg_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("Timed out waiting for the converter to drain");
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [3:0] n_in, n_out;
    logic [7:0] b;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 4'd0;
    cfg_data  = 4'd0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Reset format: 16-bit signed little-endian stereo on both sides.
    push_byte(8'h00); push_byte(8'h00);
    push_byte(8'hff); push_byte(8'h7f);
    push_byte(8'h00); push_byte(8'h80);
    push_byte(8'h01); push_byte(8'h80);
    settle();

    // Mono in, eight channels of signed 8-bit out; negatives truncate toward zero.
    cfg_write(REG_OUT_WIDE, 4'd0);
    cfg_write(REG_IN_CHANNEL_COUNT, 4'd1);
    cfg_write(REG_OUT_CHANNEL_COUNT, 4'd8);
    push_byte(8'h01); push_byte(8'h80);
    push_byte(8'hff); push_byte(8'hff);
    push_byte(8'h00); push_byte(8'h80);
    settle();

    // 8-bit offset in, 16-bit offset big-endian out. A zero input count and an
    // oversized output count give the largest fan-out; the value 2 on a one-bit
    // register keeps only its low bit, and unused indexes must change nothing.
    cfg_write(REG_IN_WIDE, 4'd0);
    cfg_write(REG_IN_SIGNED, 4'd0);
    cfg_write(REG_OUT_WIDE, 4'd1);
    cfg_write(REG_OUT_SIGNED, 4'd2);
    cfg_write(REG_OUT_BIG_ENDIAN, 4'd1);
    cfg_write(REG_IN_CHANNEL_COUNT, 4'd0);
    cfg_write(REG_OUT_CHANNEL_COUNT, 4'd15);
    cfg_write(UNUSED_REG_LO, 4'hf);
    cfg_write(UNUSED_REG_HI, 4'hf);
    push_byte(8'h00); push_byte(8'hff); push_byte(8'h80);
    settle();

    // A first byte is held when the input narrows to 8 bits.
    cfg_write(REG_IN_WIDE, 4'd1);
    cfg_write(REG_IN_BIG_ENDIAN, 4'd1);
    cfg_write(REG_IN_CHANNEL_COUNT, 4'd3);
    cfg_write(REG_OUT_CHANNEL_COUNT, 4'd2);
    cfg_write(REG_OUT_WIDE, 4'd0);
    cfg_write(REG_OUT_SIGNED, 4'd0);
    push_byte(8'h12);
    settle();
    cfg_write(REG_IN_WIDE, 4'd0);
    push_byte(8'h34);
    push_byte(8'hc0);
    settle();

    // Input count lowered with the frame at its third channel: the frame ends
    // there and the sample fills the rest of a wider output frame.
    cfg_write(REG_IN_CHANNEL_COUNT, 4'd1);
    cfg_write(REG_OUT_CHANNEL_COUNT, 4'd4);
    push_byte(8'h7f);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        n_in  = 4'd8;
        n_out = 4'd1;
      end else if (p == 1) begin
        n_in  = 4'd1;
        n_out = 4'd8;
      end else begin
        n_in  = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
        n_out = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
      end
      cfg_write(REG_IN_WIDE, 4'($urandom_range(15)));
      cfg_write(REG_IN_SIGNED, 4'($urandom_range(15)));
      cfg_write(REG_IN_BIG_ENDIAN, 4'($urandom_range(15)));
      cfg_write(REG_IN_CHANNEL_COUNT, n_in);
      cfg_write(REG_OUT_WIDE, 4'($urandom_range(15)));
      cfg_write(REG_OUT_SIGNED, 4'($urandom_range(15)));
      cfg_write(REG_OUT_BIG_ENDIAN, 4'($urandom_range(15)));
      cfg_write(REG_OUT_CHANNEL_COUNT, n_out);
      if ($urandom_range(3) == 0) cfg_write(4'($urandom_range(8, 15)), 4'($urandom_range(15)));

      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 53; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 53; end
        default: begin src_idle_pct = 23; sink_stall_pct = 23; end
      endcase

      repeat (PHASE_BYTES) begin
        // Full-scale and mid-scale codes turn up often among random ones.
        if ($urandom_range(3) == 0) begin
          case ($urandom_range(3))
            0: b = 8'h00;
            1: b = 8'h7f;
            2: b = 8'h80;
            default: b = 8'hff;
          endcase
        end else begin
          b = 8'($urandom_range(255));
        end
        push_byte(b);
      end
      settle();
      src_idle_pct   = 0;
      sink_stall_pct = 0;
    end

    $display("Sent %0d input bytes and checked %0d output bytes over %0d register writes,",
             bytes_sent, out_beats, reg_writes);
    $display("mixing 8/16-bit, signed/offset, both byte orders and channel counts 0 to 15.");
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
